@@ design/dfs_pkg.sv @@
`default_nettype none

package dfs_pkg;

    localparam int DEF_ENTRY_DEPTH = 1024;
    localparam int DEF_FRAME_DEPTH = 1024;
    localparam int DEF_INDEX_WIDTH = 32;

    localparam int CFG_WIDTH   = 11;
    localparam int STATE_WIDTH = 32;
    localparam int HELD_WIDTH  = 11;

    localparam logic [CFG_WIDTH-1:0] LIMIT_RESET = 11'd1024;

    typedef enum logic [1:0] {
        CMD_CLEAR      = 2'd0,
        CMD_PUSH_FRAME = 2'd1,
        CMD_PUSH_STATE = 2'd2,
        CMD_GET        = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_OVERFLOW = 2'd2,
        STAT_NO_FRAME = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_POP_WAIT,
        ST_POP_DEC,
        ST_CHECK_WAIT,
        ST_INDEX
    } fsm_t;

endpackage

`default_nettype wire

@@ design/dfs_frame_stack.sv @@
`default_nettype none
// channel   ports                                       handshake
// command   cmd, state_in                               start && !busy
// result    state_out, found, status, frames_held,      done (one cycle, no stall)
//           can_split
// config    cfg_data                                    cfg_valid && cfg_ready
//
// clear, push frame on an empty or full stack and push state or get with no frames
// finish in ST_IDLE; other pushes and a get that ends empty pass ST_CHECK, a get that
// hits also ST_INDEX; each empty frame popped above another adds ST_POP_WAIT, ST_POP_DEC,
// ST_CHECK_WAIT, ST_CHECK: one registered read port per memory, a shared start+count adder.
// rst_n clears the frame count, the split flag and the limit (to 1024).
// the result beat is registered: shown in the cycle after the last step; busy drops in that cycle.

module dfs_frame_stack #(
    parameter int ENTRY_DEPTH = dfs_pkg::DEF_ENTRY_DEPTH,
    parameter int FRAME_DEPTH = dfs_pkg::DEF_FRAME_DEPTH,
    parameter int INDEX_WIDTH = dfs_pkg::DEF_INDEX_WIDTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [1:0]                       cmd,
    input  wire logic [dfs_pkg::STATE_WIDTH-1:0]  state_in,
    output logic                                  done,
    output logic [dfs_pkg::STATE_WIDTH-1:0]       state_out,
    output logic                                  found,
    output logic [1:0]                            status,
    output logic [dfs_pkg::HELD_WIDTH-1:0]        frames_held,
    output logic                                  can_split,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [dfs_pkg::CFG_WIDTH-1:0]    cfg_data
);

    import dfs_pkg::*;

    localparam int EW  = $clog2(ENTRY_DEPTH + 1);
    localparam int TW  = $clog2(FRAME_DEPTH + 1);
    localparam int FAW = $clog2(FRAME_DEPTH);
    localparam int EAW = $clog2(ENTRY_DEPTH);
    localparam int CW  = (EW > CFG_WIDTH) ? EW : CFG_WIDTH;
    localparam int HW  = (TW > HELD_WIDTH) ? TW : HELD_WIDTH;

    typedef struct packed {
        logic [EW-1:0] first;
        logic [EW-1:0] count;
    } frame_t;

    frame_t                 frame_mem [FRAME_DEPTH];
    logic [INDEX_WIDTH-1:0] index_mem [ENTRY_DEPTH];

    fsm_t                   state_reg, state_next;
    logic [TW-1:0]          top_reg, top_next;
    logic                   split_reg, split_next;
    logic [CFG_WIDTH-1:0]   limit_reg;
    cmd_t                   cmd_reg;
    logic [STATE_WIDTH-1:0] sin_reg;
    logic                   done_reg, done_next;
    logic [STATE_WIDTH-1:0] sout_reg, sout_next;
    logic                   found_reg, found_next;
    status_t                stat_reg, stat_next;

    frame_t                 frame_q;
    logic [INDEX_WIDTH-1:0] index_q;

    logic                   fwr_en;
    logic [FAW-1:0]         fwr_addr;
    frame_t                 fwr_data;
    logic                   iwr_en;
    logic [EAW-1:0]         iwr_addr;
    logic [FAW-1:0]         frd_addr;
    logic [EAW-1:0]         ird_addr;

    logic [EW-1:0]          sum;
    logic [CW-1:0]          limit_eff;
    logic                   accept;
    logic                   full;
    cmd_t                   cmd_in;
    logic [HW-1:0]          top_ext;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cmd_in    = cmd_t'(cmd);
    assign cfg_ready = 1'b1;
    assign full      = (top_reg == TW'(FRAME_DEPTH));

    // shared adder: end of the top frame
    assign sum      = EW'(frame_q.first + frame_q.count);
    assign frd_addr = FAW'(top_reg - 1'b1);
    assign ird_addr = EAW'(sum - 1'b1);
    assign limit_eff = (CW'(limit_reg) < CW'(ENTRY_DEPTH)) ? CW'(limit_reg)
                                                             : CW'(ENTRY_DEPTH);

    assign top_ext     = HW'(top_reg);
    assign frames_held = top_ext[HELD_WIDTH-1:0];
    assign can_split   = split_reg;
    assign done        = done_reg;
    assign state_out   = sout_reg;
    assign found       = found_reg;
    assign status      = stat_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_in)
                        CMD_PUSH_FRAME:
                        begin
                            if (top_reg != '0 && !full)
                            begin
                                state_next = ST_CHECK;
                            end
                        end
                        CMD_PUSH_STATE, CMD_GET:
                        begin
                            if (top_reg != '0)
                            begin
                                state_next = ST_CHECK;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (cmd_reg == CMD_GET)
                begin
                    if (frame_q.count != '0)
                    begin
                        state_next = ST_INDEX;
                    end
                    else if (top_reg == TW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_POP_WAIT;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP_WAIT:   state_next = ST_POP_DEC;
            ST_POP_DEC:    state_next = ST_CHECK_WAIT;
            ST_CHECK_WAIT: state_next = ST_CHECK;
            ST_INDEX:      state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // datapath actions and result
    always_comb
    begin
        top_next   = top_reg;
        split_next = split_reg;
        done_next  = 1'b0;
        sout_next  = '0;
        found_next = 1'b0;
        stat_next  = STAT_OK;
        fwr_en     = 1'b0;
        fwr_addr   = frd_addr;
        fwr_data   = frame_q;
        iwr_en     = 1'b0;
        iwr_addr   = EAW'(sum);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_in)
                        CMD_CLEAR:
                        begin
                            top_next  = '0;
                            done_next = 1'b1;
                        end
                        CMD_PUSH_FRAME:
                        begin
                            if (full)
                            begin
                                done_next = 1'b1;
                                stat_next = STAT_OVERFLOW;
                            end
                            else if (top_reg == '0)
                            begin
                                fwr_en    = 1'b1;
                                fwr_addr  = '0;
                                fwr_data  = '0;
                                top_next  = TW'(1);
                                done_next = 1'b1;
                            end
                        end
                        CMD_PUSH_STATE:
                        begin
                            if (top_reg == '0)
                            begin
                                done_next = 1'b1;
                                stat_next = STAT_NO_FRAME;
                            end
                        end
                        CMD_GET:
                        begin
                            if (top_reg == '0)
                            begin
                                done_next = 1'b1;
                                stat_next = STAT_EMPTY;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                case (cmd_reg)
                    CMD_PUSH_FRAME:
                    begin
                        fwr_en         = 1'b1;
                        fwr_addr       = FAW'(top_reg);
                        fwr_data.first = sum;
                        fwr_data.count = '0;
                        top_next       = top_reg + 1'b1;
                        done_next      = 1'b1;
                    end
                    CMD_PUSH_STATE:
                    begin
                        done_next = 1'b1;
                        if (CW'(sum) >= limit_eff)
                        begin
                            stat_next = STAT_OVERFLOW;
                        end
                        else
                        begin
                            iwr_en         = 1'b1;
                            fwr_en         = 1'b1;
                            fwr_data.count = frame_q.count + 1'b1;
                            if (frame_q.count != '0)
                            begin
                                split_next = 1'b1;
                            end
                        end
                    end
                    CMD_GET:
                    begin
                        if (frame_q.count == '0)
                        begin
                            top_next = top_reg - 1'b1;
                            if (top_reg == TW'(1))
                            begin
                                done_next = 1'b1;
                                stat_next = STAT_EMPTY;
                            end
                        end
                    end
                    default:
                    begin
                        done_next = 1'b0;
                    end
                endcase
            end
            ST_POP_DEC:
            begin
                if (frame_q.count != '0)
                begin
                    fwr_en         = 1'b1;
                    fwr_data.count = frame_q.count - 1'b1;
                end
            end
            ST_INDEX:
            begin
                done_next  = 1'b1;
                found_next = 1'b1;
                sout_next  = STATE_WIDTH'(index_q);
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            top_reg   <= '0;
            split_reg <= 1'b0;
            limit_reg <= LIMIT_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            split_reg <= split_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_in;
            sin_reg <= state_in;
        end
        sout_reg  <= sout_next;
        found_reg <= found_next;
        stat_reg  <= stat_next;
    end

    // frame memory
    always_ff @(posedge clk)
    begin
        if (fwr_en)
        begin
            frame_mem[fwr_addr] <= fwr_data;
        end
        frame_q <= frame_mem[frd_addr];
    end

    // index memory
    always_ff @(posedge clk)
    begin
        if (iwr_en)
        begin
            index_mem[iwr_addr] <= INDEX_WIDTH'(sin_reg);
        end
        index_q <= index_mem[ird_addr];
    end

endmodule

`default_nettype wire
